[rtl/core/csdp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdp_pkg
// Types and constants shared by the divider programmer modules.
// ----------------------------------------------------------------------------
package csdp_pkg;

	typedef struct packed {
		logic [26:0] frequency;
		logic [1:0]  sideband;
	} csdp_in_t;

	typedef struct packed {
		logic [7:0] reg_address;
		logic [7:0] reg_data;
		logic       last;
	} csdp_out_t;

	localparam logic [2:0] REG_VCO     = 3'd0;
	localparam logic [2:0] REG_SHIFT   = 3'd1;
	localparam logic [2:0] REG_OFFSET  = 3'd2;
	localparam logic [2:0] REG_DIVISOR = 3'd3;
	localparam logic [2:0] REG_SCALE   = 3'd4;
	localparam logic [2:0] REG_CHANNEL = 3'd5;

	localparam logic [1:0] SB_USB = 2'd1;
	localparam logic [1:0] SB_LSB = 2'd2;

	localparam logic [27:0] TARGET_MAX = 28'hFFFFFFF;

	// Datapath operations requested by the controller.
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_LOAD   = 3'd1;
	localparam logic [2:0] OP_DIVSTEP = 3'd2;
	localparam logic [2:0] OP_DIVSETUP = 3'd3;
	localparam logic [2:0] OP_MOVE   = 3'd4;
	localparam logic [2:0] OP_ENCODE = 3'd5;

	// Selects which division the shared divider performs.
	localparam logic [2:0] DV_TARGET = 3'd0;
	localparam logic [2:0] DV_VCO    = 3'd1;
	localparam logic [2:0] DV_FRAC   = 3'd2;
	localparam logic [2:0] DV_GCD    = 3'd3;
	localparam logic [2:0] DV_RB     = 3'd4;
	localparam logic [2:0] DV_RC     = 3'd5;
	localparam logic [2:0] DV_Q      = 3'd6;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] dv;
	} csdp_cmd_t;

	typedef struct packed {
		logic target_zero;
		logic target_same;
		logic gcd_done;
	} csdp_status_t;

endpackage
`default_nettype wire

[rtl/core/csdp_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdp_datapath
// Registers, bit-serial divider and encoder for the divider computation.
// ----------------------------------------------------------------------------
module csdp_datapath
	import csdp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire csdp_in_t     in_item,
	input  wire logic [29:0]  vco_frequency,
	input  wire logic [13:0]  sideband_shift,
	input  wire logic [26:0]  frequency_offset,
	input  wire logic [4:0]   frequency_divisor,
	input  wire logic [19:0]  fraction_scale,
	input  wire logic [2:0]   multisynth_channel,
	input  wire csdp_cmd_t    cmd,
	input  wire logic [3:0]   idx,
	output csdp_status_t      status,
	output csdp_out_t         out_item
);

	// Shared restoring divider: numerator in num_q, remainder in rem_q, 48 bits.
	logic [47:0] num_q, den_q, rem_q;
	logic [27:0] target_q, last_q;
	logic [29:0] a_q;
	logic [19:0] b_q, c_q, g_x_q, g_y_q;
	logic [27:0] fr_q;
	logic [26:0] q_q;
	logic [17:0] p1_q, p2_q;
	logic [28:0] sum_q;

	logic [48:0] trial;
	logic [47:0] rsh;
	always_comb begin
		rsh   = {rem_q[46:0], num_q[47]};
		trial = {1'b0, rsh} - {1'b0, den_q};
	end

	logic [28:0] s_add;
	always_comb begin
		s_add = {2'b0, in_item.frequency} + {2'b0, frequency_offset};
		if (in_item.sideband == SB_USB)
			s_add = s_add + {15'b0, sideband_shift};
		else if (in_item.sideband == SB_LSB)
			s_add = (s_add >= {15'b0, sideband_shift}) ?
				s_add - {15'b0, sideband_shift} : '0;
	end

	logic [47:0] quo;
	assign quo = num_q;

	logic [27:0] tgt;
	assign tgt = (|quo[47:28]) ? TARGET_MAX : quo[27:0];

	assign status.target_zero = (target_q == '0);
	assign status.target_same = (target_q == last_q);
	assign status.gcd_done    = (g_y_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (cmd.op == OP_MOVE && cmd.dv == DV_VCO) begin
			last_q <= target_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				sum_q <= s_add;
			end
			OP_DIVSETUP: begin
				rem_q <= '0;
				unique case (cmd.dv)
					DV_TARGET: begin
						num_q <= {19'b0, sum_q};
						den_q <= {43'b0, (frequency_divisor == '0) ? 5'd1 : frequency_divisor};
					end
					DV_VCO: begin
						num_q <= {18'b0, vco_frequency};
						den_q <= {20'b0, target_q};
					end
					DV_FRAC: begin
						num_q <= {20'b0, fr_q} * {28'b0, c_q};
						den_q <= {20'b0, target_q};
					end
					DV_GCD: begin
						num_q <= {28'b0, g_x_q};
						den_q <= {28'b0, g_y_q};
					end
					DV_RB: begin
						num_q <= {28'b0, b_q};
						den_q <= {28'b0, g_x_q};
					end
					DV_RC: begin
						num_q <= {28'b0, c_q};
						den_q <= {28'b0, g_x_q};
					end
					DV_Q: begin
						num_q <= {21'b0, b_q, 7'b0};
						den_q <= {28'b0, c_q};
					end
					default: ;
				endcase
			end
			OP_DIVSTEP: begin
				if (!trial[48]) begin
					rem_q <= trial[47:0];
					num_q <= {num_q[46:0], 1'b1};
				end else begin
					rem_q <= rsh;
					num_q <= {num_q[46:0], 1'b0};
				end
			end
			OP_MOVE: begin
				unique case (cmd.dv)
					DV_TARGET: target_q <= tgt;
					DV_VCO: begin
						a_q  <= quo[29:0];
						fr_q <= rem_q[27:0];
						c_q  <= (fraction_scale == '0) ? 20'd1 : fraction_scale;
					end
					DV_FRAC: begin
						b_q   <= quo[19:0];
						g_x_q <= quo[19:0];
						g_y_q <= c_q;
					end
					DV_GCD: begin
						g_x_q <= g_y_q;
						g_y_q <= rem_q[19:0];
					end
					DV_RB: b_q <= quo[19:0];
					DV_RC: c_q <= quo[19:0];
					DV_Q:  q_q <= quo[26:0];
					default: ;
				endcase
			end
			OP_ENCODE: begin
				p1_q <= 18'({a_q, 7'b0} + {10'b0, q_q} - 37'd512);
				p2_q <= 18'({b_q, 7'b0} - 27'(c_q * q_q[7:0]));
			end
			default: ;
		endcase
	end

	logic [7:0] base;
	assign base = 8'd42 + {2'b0, multisynth_channel, 3'b0};

	always_comb begin
		out_item.last = 1'b0;
		out_item.reg_address = base + {4'b0, idx} - 8'd1;
		out_item.reg_data = 8'h00;
		case (idx)
			4'd0: begin out_item.reg_address = 8'd3; out_item.reg_data = 8'hFF; end
			4'd1: out_item.reg_data = c_q[15:8];
			4'd2: out_item.reg_data = c_q[7:0];
			4'd3: out_item.reg_data = {6'b0, p1_q[17:16]};
			4'd4: out_item.reg_data = p1_q[15:8];
			4'd5: out_item.reg_data = p1_q[7:0];
			4'd6: out_item.reg_data = {c_q[19:16], 2'b0, p2_q[17:16]};
			4'd7: out_item.reg_data = p2_q[15:8];
			4'd8: out_item.reg_data = p2_q[7:0];
			4'd9: begin out_item.reg_address = 8'd177; out_item.reg_data = 8'hA0; end
			default: begin
				out_item.reg_address = 8'd3; out_item.reg_data = 8'hFE;
				out_item.last = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/csdp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csdp_ctrl
// Sequencer that drives the shared divider and emits the write sequence.
// ----------------------------------------------------------------------------
module csdp_ctrl
	import csdp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire csdp_status_t  status,
	output csdp_cmd_t          cmd,
	output logic [3:0]         idx
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SETUP = 3'd1;
	localparam logic [2:0] S_STEP  = 3'd2;
	localparam logic [2:0] S_MOVE  = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_ENC   = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] dv_q;
	logic [5:0] cnt_q;
	logic [3:0] idx_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign idx = idx_q;

	always_comb begin
		cmd.dv = dv_q;
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:  cmd.op = (in_valid) ? OP_LOAD : OP_NONE;
			S_SETUP: cmd.op = OP_DIVSETUP;
			S_STEP:  cmd.op = OP_DIVSTEP;
			S_MOVE:  cmd.op = OP_MOVE;
			S_ENC:   cmd.op = OP_ENCODE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dv_q <= DV_TARGET;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					dv_q <= DV_TARGET;
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					cnt_q <= '0;
					state_q <= S_STEP;
				end
				S_STEP: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd47) state_q <= S_MOVE;
				end
				S_MOVE: state_q <= S_CHECK;
				S_CHECK: begin
					state_q <= S_SETUP;
					case (dv_q)
						DV_TARGET: if (status.target_zero || status.target_same)
								state_q <= S_IDLE;
							else dv_q <= DV_VCO;
						DV_VCO: dv_q <= DV_FRAC;
						DV_FRAC, DV_GCD: begin
							if (status.gcd_done) dv_q <= DV_RB;
							else dv_q <= DV_GCD;
						end
						DV_RB: dv_q <= DV_RC;
						DV_RC: dv_q <= DV_Q;
						default: state_q <= S_ENC;
					endcase
				end
				S_ENC: begin
					idx_q <= '0;
					state_q <= S_EMIT;
				end
				default: if (out_ready) begin
					if (idx_q == 4'd10) state_q <= S_IDLE;
					idx_q <= idx_q + 4'd1;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_ready && idx_q == 4'd10) |=> state_q == S_IDLE)
		else $error("write sequence did not end after eleven writes");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STEP |-> cnt_q <= 6'd47)
		else $error("divider step count overran");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> idx_q <= 4'd10)
		else $error("write index out of range");

endmodule
`default_nettype wire

[rtl/core/clock_synth_divider_programmer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_synth_divider_programmer_unit
// Turns a tuning request into the multisynth divider register writes.
// ----------------------------------------------------------------------------
// Each division pass runs setup, the bit-serial divider steps, move and check;
// a new target takes passes for the target, VCO ratio, fraction, each gcd step,
// reduced B and C and the quotient, then an encode step and eleven write results
// at one per cycle when out_ready is held high. An unchanged or zero target
// returns to idle after the first pass. One request at a time. Reset restores
// register defaults and clears the stored target.
module clock_synth_divider_programmer_unit
	import csdp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire csdp_in_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output csdp_out_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [29:0] cfg_data
);

	logic [29:0] vco_q;
	logic [13:0] shift_q;
	logic [26:0] offset_q;
	logic [4:0]  divisor_q;
	logic [19:0] scale_q;
	logic [2:0]  channel_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vco_q <= 30'd730560000;
			shift_q <= 14'd1500;
			offset_q <= 27'd21600000;
			divisor_q <= 5'd5;
			scale_q <= 20'd1000000;
			channel_q <= 3'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VCO:     vco_q <= cfg_data;
				REG_SHIFT:   shift_q <= cfg_data[13:0];
				REG_OFFSET:  offset_q <= cfg_data[26:0];
				REG_DIVISOR: divisor_q <= cfg_data[4:0];
				REG_SCALE:   scale_q <= cfg_data[19:0];
				REG_CHANNEL: channel_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	csdp_cmd_t    cmd;
	csdp_status_t status;
	logic [3:0]   idx;

	csdp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.cmd(cmd), .idx(idx)
	);

	csdp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data),
		.vco_frequency(vco_q), .sideband_shift(shift_q),
		.frequency_offset(offset_q), .frequency_divisor(divisor_q),
		.fraction_scale(scale_q), .multisynth_channel(channel_q),
		.cmd(cmd), .idx(idx), .status(status), .out_item(out_data)
	);

endmodule
`default_nettype wire

[dv/clock_synth_divider_programmer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider programmer unit testbench
// Sends tuning requests under varied register settings and checks every
// synthesizer register write against an independent prediction of the
// target frequency, the divider encoding and the write sequence.
// ----------------------------------------------------------------------------
module clock_synth_divider_programmer_unit_tb;
	import csdp_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int SETTLE_CYCLES = 300;
	localparam int LONG_HOLD = 3000;
	localparam logic [63:0] TARGET_CEIL = 64'h0FFF_FFFF;

	class divider_write_scoreboard;
		logic [29:0] vco;
		logic [13:0] shift;
		logic [26:0] offset;
		logic [4:0]  divisor;
		logic [19:0] scale;
		logic [2:0]  channel;
		logic [27:0] last_target;
		csdp_out_t   pending_writes[$];
		int errors;
		int writes_checked;
		int programs;
		int unchanged;

		function new();
			vco = 30'd730560000;
			shift = 14'd1500;
			offset = 27'd21600000;
			divisor = 5'd5;
			scale = 20'd1000000;
			channel = 3'd0;
			last_target = '0;
			errors = 0;
			writes_checked = 0;
			programs = 0;
			unchanged = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [29:0] value);
			case (idx)
				REG_VCO: vco = value;
				REG_SHIFT: shift = value[13:0];
				REG_OFFSET: offset = value[26:0];
				REG_DIVISOR: divisor = value[4:0];
				REG_SCALE: scale = value[19:0];
				REG_CHANNEL: channel = value[2:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
			logic [63:0] t;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			return x;
		endfunction

		function void push_write(logic [7:0] addr, logic [7:0] data, logic fin);
			csdp_out_t w;
			w.reg_address = addr;
			w.reg_data = data;
			w.last = fin;
			pending_writes.push_back(w);
		endfunction

		function void note_request(csdp_in_t req);
			logic [63:0] sum, div, tgt, a, rem, c, b, g, q, p1, p2, p3;
			logic [7:0] base;
			sum = 64'(req.frequency) + 64'(offset);
			if (req.sideband == SB_USB)
				sum = sum + 64'(shift);
			else if (req.sideband == SB_LSB)
				sum = (sum >= 64'(shift)) ? sum - 64'(shift) : 64'd0;
			div = (divisor == 0) ? 64'd1 : 64'(divisor);
			tgt = sum / div;
			if (tgt > TARGET_CEIL)
				tgt = TARGET_CEIL;
			if (tgt == 0 || tgt[27:0] == last_target) begin
				unchanged++;
				return;
			end
			last_target = tgt[27:0];
			programs++;
			a = 64'(vco) / tgt;
			rem = 64'(vco) % tgt;
			c = (scale == 0) ? 64'd1 : 64'(scale);
			b = (rem * c) / tgt;
			g = gcd_of(b, c);
			b = b / g;
			c = c / g;
			q = (128 * b) / c;
			p1 = (128 * a + q - 512) & 64'h3FFFF;
			p2 = (128 * b - c * q) & 64'h3FFFF;
			p3 = c & 64'hFFFFF;
			base = 8'(42 + 8 * int'(channel));
			push_write(8'd3, 8'hFF, 1'b0);
			push_write(base, 8'(p3 >> 8), 1'b0);
			push_write(base + 8'd1, 8'(p3), 1'b0);
			push_write(base + 8'd2, 8'((p1 >> 16) & 3), 1'b0);
			push_write(base + 8'd3, 8'(p1 >> 8), 1'b0);
			push_write(base + 8'd4, 8'(p1), 1'b0);
			push_write(base + 8'd5, 8'(((p3 >> 12) & 8'hF0) | ((p2 >> 16) & 3)), 1'b0);
			push_write(base + 8'd6, 8'(p2 >> 8), 1'b0);
			push_write(base + 8'd7, 8'(p2), 1'b0);
			push_write(8'd177, 8'hA0, 1'b0);
			push_write(8'd3, 8'hFE, 1'b1);
		endfunction

		function void check_write(csdp_out_t got);
			csdp_out_t want;
			writes_checked++;
			if (pending_writes.size() == 0) begin
				errors++;
				$display("%0t: unexpected write, expected none, actual addr=%0d data=%02h last=%0b",
					$time, got.reg_address, got.reg_data, got.last);
				return;
			end
			want = pending_writes.pop_front();
			if (got.reg_address !== want.reg_address) begin
				errors++;
				$display("%0t: reg_address mismatch, expected %0d, actual %0d",
					$time, want.reg_address, got.reg_address);
			end
			if (got.reg_data !== want.reg_data) begin
				errors++;
				$display("%0t: reg_data mismatch at addr %0d, expected %02h, actual %02h",
					$time, want.reg_address, want.reg_data, got.reg_data);
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last mismatch at addr %0d, expected %0b, actual %0b",
					$time, want.reg_address, want.last, got.last);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	csdp_in_t    in_data;
	logic        out_valid;
	logic        out_ready;
	csdp_out_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [29:0] cfg_data;

	divider_write_scoreboard sb = new();
	int burst_left = 0;
	int requests_sent = 0;
	int cycle_count = 0;
	csdp_in_t prev_request = '0;

	clock_synth_divider_programmer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Handshake signals only change at rising edges, so the falling edge
	// sees the values that the next rising edge will act on.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_write(out_data);
	end

	// The receiver switches among random stall patterns, and once
	// holds off long enough for the sender to back up against the block.
	initial begin
		int pattern;
		bit held;
		held = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			pattern = $urandom_range(0, 3);
			repeat (64) begin
				@(posedge clk);
				if (!held && sb.writes_checked >= 600) begin
					held = 1;
					out_ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end
				case (pattern)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic write_register(logic [2:0] idx, logic [29:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		forever begin
			@(negedge clk);
			if (cfg_ready)
				break;
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_register(idx, value);
		@(posedge clk);
	endtask

	// Called at a rising edge; returns at the edge that accepted the request.
	task automatic send_request(logic [26:0] freq, logic [1:0] sb_mode);
		csdp_in_t req;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.frequency = freq;
		req.sideband = sb_mode;
		in_valid <= 1'b1;
		in_data <= req;
		forever begin
			@(negedge clk);
			if (in_ready)
				break;
		end
		@(posedge clk);
		sb.note_request(req);
		prev_request = req;
		requests_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [29:0] pick_value(logic [2:0] idx);
		int sel;
		sel = $urandom_range(0, 9);
		case (idx)
			REG_VCO: return (sel == 0) ? 30'd100000000 : (sel == 1) ? 30'h3FFFFFFF :
				30'($urandom_range(100000000, 1073741823));
			REG_SHIFT: return (sel == 0) ? 30'd0 : (sel == 1) ? 30'd16383 :
				30'($urandom_range(0, 10000));
			REG_OFFSET: return (sel == 0) ? 30'd10016 : (sel == 1) ? 30'h7FFFFFF :
				30'($urandom_range(10016, 100000000));
			REG_DIVISOR: return (sel == 0) ? 30'd0 : (sel == 1) ? 30'd31 :
				30'($urandom_range(1, 16));
			REG_SCALE: return (sel == 0) ? 30'd1 : (sel == 1) ? 30'hFFFFF :
				30'($urandom_range(1, 1048575));
			default: return 30'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic logic [26:0] pick_frequency();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 13)
			return 27'($urandom_range(0, 100000000));
		else if (sel < 16)
			return 27'($urandom_range(0, 50000));
		else if (sel < 18)
			return 27'($urandom);
		else
			return (sel == 18) ? 27'd0 : 27'h7FFFFFF;
	endfunction

	initial begin
		logic [2:0] idx;
		int count;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_VCO;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: plain, repeated, every sideband code.
		send_request(27'd7000000, 2'd0);
		send_request(27'd7000000, 2'd0);
		send_request(27'd7000000, SB_USB);
		send_request(27'd7000000, SB_LSB);
		send_request(27'd7000000, 2'd3);
		send_request(27'd0, SB_LSB);
		send_request(27'h7FFFFFF, SB_USB);
		send_request(27'd14074000, SB_USB);
		settle();

		// Zero offset with the largest shift: zero targets and a tiny divisor
		// that wraps P1, channel seven giving the highest addresses.
		write_register(REG_VCO, 30'h3FFFFFFF);
		write_register(REG_SHIFT, 30'd16383);
		write_register(REG_OFFSET, 30'd0);
		write_register(REG_DIVISOR, 30'd16);
		write_register(REG_SCALE, 30'd1);
		write_register(REG_CHANNEL, 30'd7);
		send_request(27'd0, SB_LSB);
		send_request(27'd100, 2'd0);
		send_request(27'd10000, SB_USB);
		send_request(27'd10000, SB_LSB);
		send_request(27'd1, SB_USB);
		settle();

		// Divisor zero, full offset: the target saturates; scale zero.
		write_register(REG_VCO, 30'd100000000);
		write_register(REG_OFFSET, 30'h7FFFFFF);
		write_register(REG_DIVISOR, 30'd0);
		write_register(REG_SCALE, 30'd0);
		write_register(REG_CHANNEL, 30'd6);
		send_request(27'h7FFFFFF, SB_USB);
		send_request(27'h7FFFFFF, 2'd0);
		send_request(27'd0, 2'd0);
		send_request(27'd5555555, SB_LSB);
		settle();

		write_register(REG_SCALE, 30'hFFFFF);
		write_register(REG_DIVISOR, 30'd1);
		write_register(REG_CHANNEL, 30'd5);
		write_register(REG_OFFSET, 30'd10016);
		write_register(REG_VCO, 30'd900000000);
		send_request(27'd100000000, SB_USB);
		send_request(27'd3, SB_LSB);
		send_request(27'd12345678, 2'd3);
		settle();

		for (int phase = 0; phase < 6; phase++) begin
			for (int r = 0; r < 6; r++) begin
				idx = 3'(r);
				if (phase == 0 || $urandom_range(0, 2) != 0)
					write_register(idx, pick_value(idx));
			end
			// Keep the usual case dominant so most requests program the divider.
			if (phase % 2 == 0)
				write_register(REG_DIVISOR, 30'($urandom_range(1, 16)));
			count = 0;
			while (count < 75) begin
				if ($urandom_range(0, 9) == 0)
					send_request(prev_request.frequency, prev_request.sideband);
				else
					send_request(pick_frequency(), 2'($urandom_range(0, 3)));
				count++;
			end
			settle();
		end

		$display("Sent %0d tuning requests: %0d reprogrammed the divider, %0d left it alone.",
			requests_sent, sb.programs, sb.unchanged);
		$display("Checked %0d register writes in %0d cycles.", sb.writes_checked, cycle_count);
		if (sb.errors == 0 && sb.pending_writes.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
